/* rtl/lpre_pkg.sv */
`default_nettype none

package lpre_pkg;

	// fixed field widths
	localparam int CFG_W   = 4;
	localparam int FRAME_W = 3;
	localparam int FAULT_W = 32;

	// frames_in_use after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// saturation ceiling of the fault counter
	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPDATE
	} state_t;

endpackage

`default_nettype wire

/* rtl/lru_page_replacement_engine.sv */
`default_nettype none

// result: done is registered from the update state, which follows the scan and ST_LAST
// flow: busy blocks new references until idle; the single read port of the frame tables
// is walked once per reference, one frame per cycle, then the update state commits it
// reset: all frames empty, reference stamp and fault count zero, frames_in_use = 8
// each result is driven for exactly one cycle under done; the receiver cannot stall
module lru_page_replacement_engine #(
	parameter int FRAMES     = 8,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              cfg_we,
	input  wire [lpre_pkg::CFG_W-1:0]        cfg_wdata,
	// reference command
	input  wire                              start,
	output logic                             busy,
	input  wire [PAGE_BITS-1:0]              page,
	// result
	output logic                             done,
	output logic                             hit,
	output logic [lpre_pkg::FRAME_W-1:0]     frame,
	output logic                             evicted_valid,
	output logic [PAGE_BITS-1:0]             evicted_page,
	output logic [lpre_pkg::FAULT_W-1:0]     fault_count
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam int LW    = (CNT_W > lpre_pkg::CFG_W) ? CNT_W : lpre_pkg::CFG_W;

	// frame tables, written only in the update cycle
	logic [PAGE_BITS-1:0]  page_mem [FRAMES];
	logic [STAMP_BITS-1:0] use_mem  [FRAMES];
	logic [FRAMES-1:0]     valid_q;

	lpre_pkg::state_t state_q, state_d;

	logic [lpre_pkg::CFG_W-1:0] frames_in_use_q;
	logic [IDX_W-1:0]           last_idx;
	logic [LW-1:0]              cfg_ext;

	logic [IDX_W-1:0]      idx_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [lpre_pkg::FAULT_W-1:0] faults_q;

	// read stage
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic                  valid_s1;
	logic [PAGE_BITS-1:0]  rd_page_s1;
	logic [STAMP_BITS-1:0] rd_use_s1;

	// scan trackers
	logic                  match_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [STAMP_BITS-1:0] best_age_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [PAGE_BITS-1:0]  best_page_q;

	logic                  accept;
	logic                  rd_en;
	logic                  commit;
	logic [STAMP_BITS-1:0] age;
	logic [IDX_W-1:0]      slot;

	// result registers
	logic                  done_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      frame_q;
	logic                  ev_valid_q;
	logic [PAGE_BITS-1:0]  ev_page_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lpre_pkg::CFG_RESET;
		end else if (cfg_we) begin
			frames_in_use_q <= cfg_wdata;
		end
	end

	// last frame index to scan: zero acts as one, large values clamp to FRAMES
	always_comb begin
		cfg_ext = LW'(frames_in_use_q);
		if (cfg_ext == '0) begin
			last_idx = '0;
		end else if (cfg_ext > LW'(FRAMES)) begin
			last_idx = IDX_W'(LW'(FRAMES) - LW'(1));
		end else begin
			last_idx = IDX_W'(cfg_ext - LW'(1));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpre_pkg::ST_IDLE: begin
				if (start) state_d = lpre_pkg::ST_SCAN;
			end
			lpre_pkg::ST_SCAN: begin
				if (idx_q == last_idx) state_d = lpre_pkg::ST_LAST;
			end
			lpre_pkg::ST_LAST:   state_d = lpre_pkg::ST_UPDATE;
			lpre_pkg::ST_UPDATE: state_d = lpre_pkg::ST_IDLE;
			default:             state_d = lpre_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy   = 1'b1;
		rd_en  = 1'b0;
		commit = 1'b0;
		case (state_q)
			lpre_pkg::ST_IDLE:   busy   = 1'b0;
			lpre_pkg::ST_SCAN:   rd_en  = 1'b1;
			lpre_pkg::ST_LAST:   ;
			lpre_pkg::ST_UPDATE: commit = 1'b1;
			default:             ;
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpre_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan index and latched command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= '0;
		end else if (rd_en && idx_q != last_idx) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) page_q <= page;
	end

	// table read port, one frame per cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_page_s1 <= page_mem[idx_q];
			rd_use_s1  <= use_mem[idx_q];
			valid_s1   <= valid_q[idx_q];
			cmp_idx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
		end
	end

	// shared compare unit: page match, first free frame, oldest stamp
	assign age = stamp_q - rd_use_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			match_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			best_age_q  <= '0;
			best_idx_q  <= '0;
			best_page_q <= '0;
		end else if (accept) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (valid_s1 && rd_page_s1 == page_q && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= cmp_idx_s1;
			end
			if (!valid_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= cmp_idx_s1;
			end
			if (cmp_idx_s1 == '0 || age > best_age_q) begin
				best_age_q  <= age;
				best_idx_q  <= cmp_idx_s1;
				best_page_q <= rd_page_s1;
			end
		end
	end

	// frame chosen for this reference
	always_comb begin
		if (match_q) begin
			slot = match_idx_q;
		end else if (free_q) begin
			slot = free_idx_q;
		end else begin
			slot = best_idx_q;
		end
	end

	// table write port
	always_ff @(posedge clk) begin
		if (commit) begin
			use_mem[slot] <= stamp_q;
			if (!match_q) page_mem[slot] <= page_q;
		end
	end

	// occupancy, stamp and fault count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			stamp_q  <= '0;
			faults_q <= '0;
		end else if (commit) begin
			stamp_q <= stamp_q + STAMP_BITS'(1);
			if (!match_q) begin
				valid_q[slot] <= 1'b1;
				if (faults_q != lpre_pkg::FAULT_MAX) faults_q <= faults_q + 1'b1;
			end
		end
	end

	// result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= commit;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q      <= match_q;
			frame_q    <= slot;
			ev_valid_q <= !match_q && !free_q;
			ev_page_q  <= (!match_q && !free_q) ? best_page_q : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame         = lpre_pkg::FRAME_W'(frame_q);
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = faults_q;

`ifndef ASSERT_OFF
	// a result only follows an update cycle
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == lpre_pkg::ST_UPDATE))
		else $error("result strobe without update");

	// a hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted_valid))
		else $error("hit with eviction");

	// compare data only arrives while a scan is under way
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (state_q == lpre_pkg::ST_SCAN || state_q == lpre_pkg::ST_LAST))
		else $error("compare outside scan");

	// an accepted command makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accept");
`endif

endmodule

`default_nettype wire

/* tb/lru_ref_checker.sv */
`default_nettype none

module lru_ref_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [lpre_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire                           start,
	input  wire                           busy,
	input  wire [15:0]                    page,
	input  wire                           done,
	input  wire                           hit,
	input  wire [lpre_pkg::FRAME_W-1:0]   frame,
	input  wire                           evicted_valid,
	input  wire [15:0]                    evicted_page,
	input  wire [lpre_pkg::FAULT_W-1:0]   fault_count,
	output int                            pending_refs,
	output int                            fail_count
);

	localparam int FRAMES = 8;

	typedef struct packed {
		logic                          hit;
		logic [lpre_pkg::FRAME_W-1:0]  frame;
		logic                          ev_valid;
		logic [15:0]                   ev_page;
		logic [lpre_pkg::FAULT_W-1:0]  faults;
	} ref_result_t;

	// shadow copy of the frame table
	logic [15:0]                  frame_pg    [FRAMES];
	bit                           frame_full  [FRAMES];
	logic [31:0]                  frame_stamp [FRAMES];
	logic [31:0]                  ref_clock;
	logic [lpre_pkg::FAULT_W-1:0] fault_tally;
	logic [lpre_pkg::CFG_W-1:0]   frames_cfg;

	ref_result_t expected_refs[$];
	int          issued;
	int          retired;
	int          fails;

	assign pending_refs = issued - retired;
	assign fail_count   = fails;

	// register value clamped to the usable frame range
	function automatic int unsigned live_frames(input logic [lpre_pkg::CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > FRAMES)
			return FRAMES;
		return 32'(v);
	endfunction

	// lookup, fill or lru eviction, then stamp update
	task automatic predict_reference(input logic [15:0] pg, output ref_result_t r);
		int unsigned n;
		int unsigned slot;
		int unsigned i;
		bit          found;
		bit          free_found;
		logic [31:0] age;
		logic [31:0] best_age;
		n          = live_frames(frames_cfg);
		slot       = 0;
		found      = 0;
		free_found = 0;
		best_age   = '0;
		r          = '0;
		for (i = 0; i < n; i++) begin
			if (!found && frame_full[i] && frame_pg[i] == pg) begin
				slot  = i;
				found = 1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
		end else begin
			for (i = 0; i < n; i++) begin
				if (!free_found && !frame_full[i]) begin
					slot       = i;
					free_found = 1;
				end
			end
			if (!free_found) begin
				slot = 0;
				for (i = 0; i < n; i++) begin
					age = ref_clock - frame_stamp[i];
					if (i == 0 || age > best_age) begin
						best_age = age;
						slot     = i;
					end
				end
				r.ev_valid = 1'b1;
				r.ev_page  = frame_pg[slot];
			end
			frame_pg[slot]   = pg;
			frame_full[slot] = 1'b1;
			if (fault_tally != lpre_pkg::FAULT_MAX)
				fault_tally = fault_tally + 1'b1;
		end
		frame_stamp[slot] = ref_clock;
		ref_clock         = ref_clock + 1'b1;
		r.frame           = slot[lpre_pkg::FRAME_W-1:0];
		r.faults          = fault_tally;
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		ref_result_t want;
		int          bad;
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				frame_pg[i]    = '0;
				frame_full[i]  = 1'b0;
				frame_stamp[i] = '0;
			end
			ref_clock   = '0;
			fault_tally = '0;
			frames_cfg  = lpre_pkg::CFG_RESET;
			expected_refs.delete();
			issued  <= 0;
			retired <= 0;
			fails   <= 0;
		end else begin
			bad = 0;
			// result transfer against the oldest expectation
			if (done) begin
				if (expected_refs.size() == 0) begin
					$error("result transfer with no reference outstanding");
					bad++;
				end else begin
					want = expected_refs.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, hit);
						bad++;
					end
					if (frame !== want.frame) begin
						$error("frame: expected %0d, actual %0d", want.frame, frame);
						bad++;
					end
					if (evicted_valid !== want.ev_valid) begin
						$error("evicted_valid: expected %0d, actual %0d",
							want.ev_valid, evicted_valid);
						bad++;
					end
					if (evicted_page !== want.ev_page) begin
						$error("evicted_page: expected %h, actual %h",
							want.ev_page, evicted_page);
						bad++;
					end
					if (fault_count !== want.faults) begin
						$error("fault_count: expected %0d, actual %0d",
							want.faults, fault_count);
						bad++;
					end
					retired <= retired + 1;
				end
			end
			// reference transfer
			if (start && !busy) begin
				predict_reference(page, want);
				expected_refs.push_back(want);
				issued <= issued + 1;
			end
			if (cfg_we)
				frames_cfg = cfg_wdata;
			fails <= fails + bad;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_lru_page_replacement_engine.sv */
`default_nettype none

module tb_lru_page_replacement_engine;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lpre_pkg::CFG_W-1:0]     cfg_wdata;
	logic                           start;
	logic [15:0]                    page;
	wire                            busy;
	wire                            done;
	wire                            hit;
	wire [lpre_pkg::FRAME_W-1:0]    frame;
	wire                            evicted_valid;
	wire [15:0]                     evicted_page;
	wire [lpre_pkg::FAULT_W-1:0]    fault_count;
	int                             pending_refs;
	int                             fail_count;

	logic [15:0] page_pool [16];
	int          pool_len;
	int          idle_pct;

	lru_page_replacement_engine #(
		.FRAMES     (8),
		.PAGE_BITS  (16),
		.STAMP_BITS (32)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.page          (page),
		.done          (done),
		.hit           (hit),
		.frame         (frame),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_count   (fault_count)
	);

	lru_ref_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.page          (page),
		.done          (done),
		.hit           (hit),
		.frame         (frame),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_count   (fault_count),
		.pending_refs  (pending_refs),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("lru_page_replacement_engine: mismatch");
		$finish;
	end

	// raise start with a page and hold it until the transfer
	task automatic send_ref(input logic [15:0] pg);
		start <= 1'b1;
		page  <= pg;
		do @(posedge clk); while (busy);
	endtask

	// stop issuing and wait for every outstanding result
	task automatic quiesce();
		start <= 1'b0;
		do @(posedge clk); while (pending_refs != 0 || busy);
	endtask

	// register write while the engine is idle
	task automatic write_frames(input logic [lpre_pkg::CFG_W-1:0] v);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int                         phase;
		int                         k;
		int                         roll;
		int                         idle_plan [4];
		logic [lpre_pkg::CFG_W-1:0] cfg_plan  [8];
		idle_plan = '{0, 52, 0, 16};
		cfg_plan  = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd8, 4'd2, 4'd5, 4'd7};
		cfg_plan[5] = lpre_pkg::CFG_W'($urandom_range(1, 15));

		cfg_we    = 1'b0;
		cfg_wdata = lpre_pkg::CFG_RESET;
		start     = 1'b0;
		page      = '0;
		arst_n    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill all frames from reset, hits on the extremes, then two lru evictions
		send_ref(16'h0000);
		send_ref(16'hFFFF);
		send_ref(16'h0000);
		send_ref(16'hFFFF);
		for (k = 1; k <= 6; k++)
			send_ref(k[15:0]);
		send_ref(16'h0007);
		send_ref(16'h0000);
		// shrunk count: high frames hidden, page re-fetched into a low frame
		write_frames(4'd2);
		send_ref(16'h0006);
		send_ref(16'hAAAA);
		send_ref(16'h5555);
		// grown again: the page left in a high frame hits there
		write_frames(4'd8);
		send_ref(16'h0006);
		// zero acts as one frame
		write_frames(4'd0);
		send_ref(16'hFFFF);
		send_ref(16'h1234);
		send_ref(16'h1234);
		// above range acts as all frames
		write_frames(4'd15);
		send_ref(16'h0006);
		send_ref(16'h5555);

		// random phases over a small working set with some wide noise
		for (phase = 0; phase < 8; phase++) begin
			write_frames(cfg_plan[phase]);
			idle_pct = idle_plan[phase % 4];
			pool_len = $urandom_range(2, 14);
			for (k = 0; k < 16; k++)
				page_pool[k] = 16'($urandom);
			for (k = 0; k < 150; k++) begin
				// let the pipe drain once mid-phase
				if (k == 75)
					quiesce();
				if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					page  <= 16'($urandom);
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
				roll = $urandom_range(99);
				if (roll < 85)
					send_ref(page_pool[$urandom_range(pool_len - 1)]);
				else if (roll < 90)
					send_ref($urandom_range(1) ? 16'hFFFF : 16'h0000);
				else
					send_ref(16'($urandom));
			end
		end

		quiesce();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("lru_page_replacement_engine: match");
		else
			$display("lru_page_replacement_engine: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
